>>> rtl/core/hrs_pkg.sv
// hrs_pkg: shared types, constants and the sRGB byte threshold table
// for the half-float RGBA to sRGB8 BGRA encoder. No dependencies.
package hrs_pkg;

  localparam int unsigned HALF_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  // one binary search step per result bit
  localparam int unsigned STAGES    = BYTE_W;
  localparam int unsigned TAB_DEPTH = 1 << BYTE_W;
  localparam int unsigned FRAC_BITS = 40;
  // color channels in one pixel, one lane each
  localparam int unsigned CHANNELS  = 4;

  // half patterns below this use the linear segment of the curve
  localparam logic [HALF_W-1:0] LINEAR_LIMIT = 16'h1A6A;
  // half pattern of 1.0
  localparam logic [HALF_W-1:0] ONE_HALF     = 16'h3C00;

  typedef logic [HALF_W-1:0] half_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [STAGES-1:0] stage_en_t;
  typedef logic [TAB_DEPTH-1:0][HALF_W-1:0] thresh_tab_t;

  // log2 of an integer as signed Q40, truncated, by repeated squaring
  function automatic longint log2_q40(input longint unsigned n);
    logic [127:0] sq;
    logic [63:0]  m;
    logic [63:0]  frac;
    int           p;
    p    = 0;
    frac = '0;
    for (int i = 0; i < 62; i++) begin
      if ((n >> (i + 1)) != 0) begin
        p = i + 1;
      end
    end
    m = n << (62 - p);
    for (int i = 0; i < FRAC_BITS; i++) begin
      sq   = {64'd0, m} * {64'd0, m};
      m    = sq[125:62];
      frac = frac << 1;
      if (m[63]) begin
        m       = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return longint'((64'(p) << FRAC_BITS) | frac);
  endfunction

  // true when a non-negative half h (at most 1.0) encodes to byte k or above
  function automatic bit enc_ge(input half_t h, input int k, input longint bound);
    longint e;
    longint f;
    longint n;
    longint lx;
    e = longint'(h[14:10]);
    f = longint'(h[9:0]);
    if (h < LINEAR_LIMIT) begin
      n = (e == 0) ? f : ((1024 + f) << (e - 1));
      return (32946 * n + (longint'(5) << 24)) >= (longint'(k) * (longint'(10) << 24));
    end
    lx = log2_q40(64'(1024 + f)) + (e - 25) * (longint'(1) << FRAC_BITS);
    return (lx * 20833) >= bound;
  endfunction

  // smallest half pattern reaching each byte code, entry zero is zero
  function automatic thresh_tab_t build_thresh();
    thresh_tab_t tab;
    longint      base;
    longint      bound;
    int          lo;
    int          hi;
    int          mid;
    tab    = '0;
    base   = log2_q40(64'd53805);
    lo     = 0;
    for (int k = 1; k < TAB_DEPTH; k++) begin
      bound = 50000 * (log2_q40(64'(200 * k + 2705)) - base);
      hi    = int'(ONE_HALF);
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (enc_ge(half_t'(mid), k, bound)) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      tab[k] = half_t'(lo);
    end
    return tab;
  endfunction

  localparam thresh_tab_t THRESH = build_thresh();

  // nan and negative map to zero, anything above one maps to one
  function automatic half_t clamp_half(input half_t h);
    half_t r;
    if (h[15] || ((h[14:10] == 5'h1F) && (h[9:0] != 10'd0))) begin
      r = '0;
    end else if (h > ONE_HALF) begin
      r = ONE_HALF;
    end else begin
      r = h;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/hrs_lane.sv
// hrs_lane: one channel of the encoder, a pipelined binary search of the
// byte threshold table. Depends on hrs_pkg.
module hrs_lane import hrs_pkg::*; (
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  half_t     half_i,
  output byte_t     byte_o
);

  half_t h_q [STAGES-1];
  byte_t r_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam byte_t STEP = byte_t'(1) << (STAGES - 1 - s);
    half_t h_d;
    byte_t r_in;
    byte_t cand;
    byte_t r_d;

    // stage input: clamped channel at the head, previous stage otherwise
    if (s == 0) begin : g_head
      assign h_d  = clamp_half(half_i);
      assign r_in = '0;
    end else begin : g_body
      assign h_d  = h_q[s-1];
      assign r_in = r_q[s-1];
    end

    // try setting this bit of the code
    assign cand = r_in | STEP;
    assign r_d  = (THRESH[cand] <= h_d) ? cand : r_in;

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        r_q[s] <= r_d;
      end
    end

    // the last stage no longer needs the channel value
    if (s < STAGES - 1) begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          h_q[s] <= h_d;
        end
      end
    end
  end

  assign byte_o = r_q[STAGES-1];

endmodule

>>> rtl/core/hrs_ctrl.sv
// hrs_ctrl: valid tracking and per-stage advance enables for the lane
// pipeline, bubbles collapse under output stall. Depends on hrs_pkg.
module hrs_ctrl import hrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output stage_en_t en_o
);

  stage_en_t vld_q;
  stage_en_t vld_d;
  stage_en_t en;

  // a stage may load when it is empty or its successor moves on
  always_comb begin
    en[STAGES-1] = !vld_q[STAGES-1] || !out_stall_i;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  // next valid bits
  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int i = 1; i < STAGES; i++) begin
      if (en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en_o        = en;
  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[STAGES-1];

endmodule

>>> rtl/core/half_rgba_to_srgb8_bgra_unit.sv
// half_rgba_to_srgb8_bgra_unit: half-float RGBA pixel to sRGB8 BGRA bytes.
// Each pixel takes one step of the per-lane threshold table search per
// cycle unless stalled. Throughput: one pixel per clock while out_stall_i
// is low, four lanes in parallel. Reset clears the pipeline valid bits
// asynchronously, data registers are not reset. Depends on hrs_pkg.
module half_rgba_to_srgb8_bgra_unit import hrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  half_t red_half_i,
  input  half_t green_half_i,
  input  half_t blue_half_i,
  input  half_t alpha_half_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output byte_t out_blue_o,
  output byte_t out_green_o,
  output byte_t out_red_o,
  output byte_t out_alpha_o
);

  stage_en_t en;
  half_t     half_in  [CHANNELS];
  byte_t     lane_out [CHANNELS];

  // pipeline control
  hrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .en_o        (en)
  );

  // channels in rgba order
  assign half_in[0] = red_half_i;
  assign half_in[1] = green_half_i;
  assign half_in[2] = blue_half_i;
  assign half_in[3] = alpha_half_i;

  // one encoder lane per channel
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    hrs_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .half_i (half_in[c]),
      .byte_o (lane_out[c])
    );
  end

  // merge lane results into bgra byte order
  assign out_blue_o  = lane_out[2];
  assign out_green_o = lane_out[1];
  assign out_red_o   = lane_out[0];
  assign out_alpha_o = lane_out[3];

endmodule
